>>> hw/rtl/etrs_pkg.sv
// ----------------------------------------------------------------------------
// etrs_pkg: shared types and constants for the TRS model matrix block
// Fixed-point constants, the CORDIC arctangent table and rounding helpers.
// ----------------------------------------------------------------------------
package etrs_pkg;

    localparam int unsigned ATAN_ENTRIES = 24;
    localparam int unsigned ZW = 32;                  // Q2.30 angle/trig width
    localparam int unsigned XW = 34;                  // CORDIC datapath width

    localparam logic signed [XW-1:0] CORDIC_GAIN    = 34'sd652032874;
    localparam logic signed [25:0]   DEG64_TO_RAD   = 26'sd18740330;
    localparam logic signed [16:0]   FULL_TURN      = 17'sd23040;
    localparam logic signed [16:0]   HALF_TURN      = 17'sd11520;
    localparam logic signed [16:0]   QUARTER_TURN   = 17'sd5760;

    typedef logic signed [XW-1:0] t_trig;

    typedef struct packed {
        t_trig sin_v;
        t_trig cos_v;
    } t_sincos;

    function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:    v = 32'sd843314856;
            5'd1:    v = 32'sd497837829;
            5'd2:    v = 32'sd263043836;
            5'd3:    v = 32'sd133525158;
            5'd4:    v = 32'sd67021686;
            5'd5:    v = 32'sd33543515;
            5'd6:    v = 32'sd16775850;
            5'd7:    v = 32'sd8388437;
            5'd8:    v = 32'sd4194282;
            5'd9:    v = 32'sd2097149;
            5'd10:   v = 32'sd1048575;
            5'd11:   v = 32'sd524287;
            5'd12:   v = 32'sd262143;
            5'd13:   v = 32'sd131071;
            5'd14:   v = 32'sd65535;
            5'd15:   v = 32'sd32767;
            5'd16:   v = 32'sd16383;
            5'd17:   v = 32'sd8191;
            5'd18:   v = 32'sd4095;
            5'd19:   v = 32'sd2047;
            5'd20:   v = 32'sd1023;
            5'd21:   v = 32'sd511;
            5'd22:   v = 32'sd255;
            5'd23:   v = 32'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Round a Q2.30 x Q2.30 product back to Q2.30 (floor of sum with half).
    function automatic t_trig rnd_q30(input logic signed [67:0] p);
        logic signed [67:0] t;
        t = (p + 68'sd536870912) >>> 30;
        return t[XW-1:0];
    endfunction

endpackage

>>> hw/rtl/etrs_sincos.sv
// ----------------------------------------------------------------------------
// etrs_sincos: pipelined sine/cosine of a Q10.6 degree angle
// Range reduction, degree-to-radian scaling, then one CORDIC step per stage.
// ----------------------------------------------------------------------------
module etrs_sincos
    import etrs_pkg::*;
#(
    parameter int unsigned ITERS = 16
) (
    input  logic              i_clk,
    input  logic              i_adv,
    input  logic signed [15:0] i_angle,
    output t_sincos           o_sc
);

    localparam int unsigned NI = (ITERS > ATAN_ENTRIES) ? ATAN_ENTRIES : ITERS;

    // stage A: reduce angle into [-5760, 5760] with flip flag
    logic signed [16:0] a0, a1, a2, a3;
    logic               f0;
    always_comb begin
        a0 = 17'(i_angle);
        a1 = a0;
        if (a0 >= HALF_TURN) begin
            a1 = a0 - FULL_TURN;
        end else if (a0 < -HALF_TURN) begin
            a1 = a0 + FULL_TURN;
        end
        a2 = a1;
        if (a1 >= HALF_TURN) begin
            a2 = a1 - FULL_TURN;
        end else if (a1 < -HALF_TURN) begin
            a2 = a1 + FULL_TURN;
        end
        f0 = 1'b0;
        a3 = a2;
        if (a2 > QUARTER_TURN) begin
            a3 = a2 - HALF_TURN;
            f0 = 1'b1;
        end else if (a2 < -QUARTER_TURN) begin
            a3 = a2 + HALF_TURN;
            f0 = 1'b1;
        end
    end

    logic signed [16:0] r_ang;
    logic               r_flip_a;
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_ang    <= a3;
            r_flip_a <= f0;
        end
    end

    // stage B: radians, Q2.30
    logic signed [42:0] n_prod;
    assign n_prod = 43'(r_ang) * 43'(DEG64_TO_RAD);

    t_trig r_x [NI+1];
    t_trig r_y [NI+1];
    logic signed [ZW:0] r_z [NI+1];
    logic               r_f [NI+1];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= (ZW+1)'(n_prod >>> 6);
            r_f[0] <= r_flip_a;
        end
    end

    for (genvar i = 0; i < NI; i++) begin : g_step
        t_trig n_x, n_y;
        logic signed [ZW:0] n_z, at;
        always_comb begin
            at = (ZW+1)'(atan_q30(5'(i)));
            if (!r_z[i][ZW]) begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - at;
            end else begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + at;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_x[i+1] <= n_x;
                r_y[i+1] <= n_y;
                r_z[i+1] <= n_z;
                r_f[i+1] <= r_f[i];
            end
        end
    end

    assign o_sc.sin_v = r_f[NI] ? -r_y[NI] : r_y[NI];
    assign o_sc.cos_v = r_f[NI] ? -r_x[NI] : r_x[NI];

endmodule

>>> hw/rtl/euler_trs_model_matrix.sv
// ----------------------------------------------------------------------------
// euler_trs_model_matrix: T*R*S affine model matrix, Q16.16
// Three CORDIC pipelines, a product tree and scaled saturated output.
// ----------------------------------------------------------------------------
// channel  | ports                          | handshake
// input    | i_pos_*, i_angle_*, i_scale_*  | i_start high, o_busy low
// result   | o_m00..o_m22, o_trans_*        | o_done strobe, one cycle
//
// One item per cycle. o_busy is always low: the result side cannot stall,
// so the pipeline advances every cycle. Reset clears the valid bits only.
module euler_trs_model_matrix
    import etrs_pkg::*;
#(
    parameter int unsigned TRIG_ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [15:0] i_angle_x,
    input  logic signed [15:0] i_angle_y,
    input  logic signed [15:0] i_angle_z,
    input  logic signed [31:0] i_scale_x,
    input  logic signed [31:0] i_scale_y,
    input  logic signed [31:0] i_scale_z,
    output logic               o_done,
    output logic signed [31:0] o_m00,
    output logic signed [31:0] o_m01,
    output logic signed [31:0] o_m02,
    output logic signed [31:0] o_m10,
    output logic signed [31:0] o_m11,
    output logic signed [31:0] o_m12,
    output logic signed [31:0] o_m20,
    output logic signed [31:0] o_m21,
    output logic signed [31:0] o_m22,
    output logic signed [31:0] o_trans_x,
    output logic signed [31:0] o_trans_y,
    output logic signed [31:0] o_trans_z
);

    localparam int unsigned NI  = (TRIG_ITERATIONS > ATAN_ENTRIES) ?
                                  ATAN_ENTRIES : TRIG_ITERATIONS;
    localparam int unsigned TRG = NI + 2;     // sincos latency
    localparam int unsigned LAT = TRG + 5;    // total latency

    logic adv;
    assign adv    = 1'b1;
    assign o_busy = 1'b0;

    t_sincos scx, scy, scz;
    etrs_sincos #(.ITERS(TRIG_ITERATIONS)) u_sx (
        .i_clk(i_clk), .i_adv(adv), .i_angle(i_angle_x), .o_sc(scx));
    etrs_sincos #(.ITERS(TRIG_ITERATIONS)) u_sy (
        .i_clk(i_clk), .i_adv(adv), .i_angle(i_angle_y), .o_sc(scy));
    etrs_sincos #(.ITERS(TRIG_ITERATIONS)) u_sz (
        .i_clk(i_clk), .i_adv(adv), .i_angle(i_angle_z), .o_sc(scz));

    // valid bits and side data
    logic       r_vld [LAT];
    logic [95:0] r_pos [LAT];
    logic [95:0] r_scl [TRG+3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) r_vld[k] <= 1'b0;
        end else begin
            r_vld[0] <= i_start && !o_busy;
            for (int k = 1; k < LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos[0] <= {i_pos_x, i_pos_y, i_pos_z};
        r_scl[0] <= {i_scale_x, i_scale_y, i_scale_z};
        for (int k = 1; k < LAT; k++) r_pos[k] <= r_pos[k-1];
        for (int k = 1; k < TRG+3; k++) r_scl[k] <= r_scl[k-1];
    end
    // r_*[k] lines up with stage k; sincos output aligns with index TRG-1.

    // stage 1: sx*sz, sx*cz, and direct pair products
    t_trig r_sx, r_sy, r_cy, r_sxsz, r_sxcz;
    t_trig r_cxsz, r_cxcz, r_sycx, r_cycx, r_sysz, r_cycz, r_sycz, r_cysz;
    always_ff @(posedge i_clk) begin
        r_sx   <= scx.sin_v;
        r_sy   <= scy.sin_v;  r_cy <= scy.cos_v;
        r_sxsz <= rnd_q30(68'(scx.sin_v) * 68'(scz.sin_v));
        r_sxcz <= rnd_q30(68'(scx.sin_v) * 68'(scz.cos_v));
        r_cxsz <= rnd_q30(68'(scx.cos_v) * 68'(scz.sin_v));
        r_cxcz <= rnd_q30(68'(scx.cos_v) * 68'(scz.cos_v));
        r_sycx <= rnd_q30(68'(scy.sin_v) * 68'(scx.cos_v));
        r_cycx <= rnd_q30(68'(scy.cos_v) * 68'(scx.cos_v));
        r_sysz <= rnd_q30(68'(scy.sin_v) * 68'(scz.sin_v));
        r_cycz <= rnd_q30(68'(scy.cos_v) * 68'(scz.cos_v));
        r_sycz <= rnd_q30(68'(scy.sin_v) * 68'(scz.cos_v));
        r_cysz <= rnd_q30(68'(scy.cos_v) * 68'(scz.sin_v));
    end

    // stage 2: products with sxsz, sxcz
    t_trig r_a, r_b, r_c, r_d;
    t_trig r_p_cycz, r_p_cysz, r_p_sycx, r_p_cxsz, r_p_cxcz, r_p_msx;
    t_trig r_p_sycz, r_p_sysz, r_p_cycx;
    always_ff @(posedge i_clk) begin
        r_a <= rnd_q30(68'(r_sy) * 68'(r_sxsz));
        r_b <= rnd_q30(68'(r_sy) * 68'(r_sxcz));
        r_c <= rnd_q30(68'(r_cy) * 68'(r_sxsz));
        r_d <= rnd_q30(68'(r_cy) * 68'(r_sxcz));
        r_p_cycz <= r_cycz; r_p_cysz <= r_cysz; r_p_sycx <= r_sycx;
        r_p_cxsz <= r_cxsz; r_p_cxcz <= r_cxcz; r_p_msx <= -r_sx;
        r_p_sycz <= r_sycz; r_p_sysz <= r_sysz; r_p_cycx <= r_cycx;
    end

    // stage 3: rotation entries
    t_trig r_r [9];
    always_ff @(posedge i_clk) begin
        r_r[0] <= r_p_cycz + r_a;
        r_r[1] <= r_b - r_p_cysz;
        r_r[2] <= r_p_sycx;
        r_r[3] <= r_p_cxsz;
        r_r[4] <= r_p_cxcz;
        r_r[5] <= r_p_msx;
        r_r[6] <= r_c - r_p_sycz;
        r_r[7] <= r_p_sysz + r_d;
        r_r[8] <= r_p_cycx;
    end

    // stage 4: scale (rotation entry < 2^33, scale 32 bits)
    logic [95:0] scl_now;
    assign scl_now = r_scl[TRG+2];
    logic signed [67:0] r_prod [9];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            unique case (k % 3)
                0:       r_prod[k] <= 68'(r_r[k]) * 68'($signed(scl_now[95:64]));
                1:       r_prod[k] <= 68'(r_r[k]) * 68'($signed(scl_now[63:32]));
                default: r_prod[k] <= 68'(r_r[k]) * 68'($signed(scl_now[31:0]));
            endcase
        end
    end

    // stage 5: round and saturate
    logic signed [31:0] r_m [9];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            logic signed [67:0] v;
            v = (r_prod[k] + 68'sd536870912) >>> 30;
            if (v > 68'sd2147483647) begin
                r_m[k] <= 32'sh7fffffff;
            end else if (v < -68'sd2147483648) begin
                r_m[k] <= 32'sh80000000;
            end else begin
                r_m[k] <= v[31:0];
            end
        end
    end

    assign o_done    = r_vld[LAT-1];
    assign o_m00     = r_m[0];
    assign o_m01     = r_m[1];
    assign o_m02     = r_m[2];
    assign o_m10     = r_m[3];
    assign o_m11     = r_m[4];
    assign o_m12     = r_m[5];
    assign o_m20     = r_m[6];
    assign o_m21     = r_m[7];
    assign o_m22     = r_m[8];
    assign o_trans_x = r_pos[LAT-1][95:64];
    assign o_trans_y = r_pos[LAT-1][63:32];
    assign o_trans_z = r_pos[LAT-1][31:0];

`ifndef SYNTHESIS
    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_vld[LAT-2])) else $error("done without staged item");
    a_never_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("done right after reset");
`endif

endmodule
